/* design/bbv_pkg.sv */
// ----------------------------------------------------------------------------
// bbv_pkg
// Shared constants for the box blur block: field widths, register map
// and register reset values.
// ----------------------------------------------------------------------------
package bbv_pkg;

    // payload widths
    localparam int SAMPLE_W = 8;
    localparam int ROW_W    = 16;

    // configuration register widths
    localparam int IMG_WIDTH_W = 11;
    localparam int CHN_COUNT_W = 3;
    localparam int WIN_SIZE_W  = 4;

    // register reset values
    localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RST = 11'd640;
    localparam logic [CHN_COUNT_W-1:0] CHN_COUNT_RST = 3'd3;
    localparam logic [WIN_SIZE_W-1:0]  WIN_SIZE_RST  = 4'd3;

    // register map, word index = paddr[3:2]
    localparam int PADDR_W = 4;
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_WIDTH   = 2'd0;
    localparam t_reg_idx REG_CHANNEL_COUNT = 2'd1;
    localparam t_reg_idx REG_WINDOW_SIZE   = 2'd2;

endpackage

/* design/box_blur_valid_window.sv */
// Per item: reads the line store once for each earlier row of the window once enough
// rows are in, writes the sample and its column sum, and if a result is due reads the
// column sums, runs eight divider steps and waits for any held result to be taken.
// Throughput: one item at a time; the next is taken once the current one ends.
// Reset: synchronous, active low; afterwards a clearing pass over every
// column sum entry zeroes the column sums before any input transfer.
// ----------------------------------------------------------------------------
// box_blur_valid_window
// Streaming 2-D box blur over the valid area. Keeps the last rows in a line
// store memory and per-column vertical sums in a second memory.
// ----------------------------------------------------------------------------
module box_blur_valid_window #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_WINDOW   = 15
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bbv_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bbv_pkg::SAMPLE_W-1:0]         i_sample,
    input  logic                                 i_frame_start,
    // output stream
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bbv_pkg::SAMPLE_W-1:0]         o_blurred_sample,
    output logic                                 o_row_end
);

    localparam int ROW_SLOTS = MAX_WINDOW - 1;
    localparam int LS_ROW    = MAX_WIDTH * MAX_CHANNELS;
    localparam int LS_DEPTH  = ROW_SLOTS * LS_ROW;
    localparam int CS_DEPTH  = LS_ROW;
    localparam int LSAW      = $clog2(LS_DEPTH);
    localparam int CSAW      = $clog2(CS_DEPTH);
    localparam int COLW      = $clog2(MAX_WIDTH);
    localparam int WEW       = $clog2(MAX_WIDTH + 1);
    localparam int HW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHEW      = $clog2(MAX_CHANNELS + 1);
    localparam int KW        = $clog2(MAX_WINDOW + 1);
    localparam int SLW       = $clog2(ROW_SLOTS);
    localparam int CSW       = $clog2(MAX_WINDOW * 255 + 1);
    localparam int SUMW      = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int KKW       = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int QW        = bbv_pkg::SAMPLE_W;
    localparam int DVW       = KKW + QW - 1;
    localparam int DCW       = SUMW + DVW + 1;
    localparam int SW        = bbv_pkg::SAMPLE_W;
    localparam int RW        = bbv_pkg::ROW_W;

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LRD  = 4'd2;
    localparam logic [3:0] S_LACC = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_CRD  = 4'd5;
    localparam logic [3:0] S_CACC = 4'd6;
    localparam logic [3:0] S_DSET = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    // configuration registers
    logic [bbv_pkg::IMG_WIDTH_W-1:0] r_cfg_width;
    logic [bbv_pkg::CHN_COUNT_W-1:0] r_cfg_chn;
    logic [bbv_pkg::WIN_SIZE_W-1:0]  r_cfg_win;

    // control state
    logic [3:0]      r_state;
    logic [CSAW-1:0] r_clr_addr;
    logic [COLW-1:0] r_col;
    logic [HW-1:0]   r_chp;
    logic [RW-1:0]   r_row;
    logic [SLW-1:0]  r_slot;
    logic            r_out_valid;

    // per-item working registers
    logic [WEW-1:0]  r_w;
    logic [CHEW-1:0] r_chn;
    logic [KW-1:0]   r_k;
    logic [KKW-1:0]  r_kk;
    logic [COLW-1:0] r_c;
    logic [HW-1:0]   r_h;
    logic [SW-1:0]   r_sample;
    logic [KW-1:0]   r_j;
    logic [CSW-1:0]  r_cs;
    logic [SUMW-1:0] r_sum;
    logic [SUMW-1:0] r_rem;
    logic [DVW-1:0]  r_dvs;
    logic [QW-1:0]   r_q;
    logic [2:0]      r_step;
    logic            r_win_full;
    logic            r_out_end;
    logic [SW-1:0]   r_out_data;

    // memories
    logic [SW-1:0]   r_ls_mem [LS_DEPTH];
    logic [CSW-1:0]  r_cs_mem [CS_DEPTH];
    logic [SW-1:0]   r_ls_rd;
    logic [CSW-1:0]  r_cs_rd;

    logic            ls_rd_en, ls_wr_en, cs_rd_en, cs_wr_en;
    logic [LSAW-1:0] ls_addr;
    logic [CSAW-1:0] cs_addr;
    logic [CSW-1:0]  cs_wdata;

    logic            in_xfer, out_xfer, cfg_wr, emit_go, pos_step;
    logic [31:0]     w32, ch32, k32, rs32, tmp32;
    logic [WEW-1:0]  eff_w;
    logic [CHEW-1:0] eff_chn;
    logic [KW-1:0]   eff_k;
    logic [COLW-1:0] a_col;
    logic [HW-1:0]   a_h;
    logic [RW-1:0]   a_row;
    logic [SLW-1:0]  a_slot;
    logic [COLW-1:0] u_col;
    logic [HW-1:0]   u_h;
    logic [RW-1:0]   u_row;
    logic [SLW-1:0]  u_slot;
    logic            lines_ready, out_cond, row_end_now;
    logic [DCW-1:0]  rem_x, dvs_x;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign emit_go  = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    // configuration write and readback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= bbv_pkg::IMG_WIDTH_RST;
            r_cfg_chn   <= bbv_pkg::CHN_COUNT_RST;
            r_cfg_win   <= bbv_pkg::WIN_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bbv_pkg::REG_IMAGE_WIDTH:   r_cfg_width <= pwdata[bbv_pkg::IMG_WIDTH_W-1:0];
                bbv_pkg::REG_CHANNEL_COUNT: r_cfg_chn   <= pwdata[bbv_pkg::CHN_COUNT_W-1:0];
                bbv_pkg::REG_WINDOW_SIZE:   r_cfg_win   <= pwdata[bbv_pkg::WIN_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            bbv_pkg::REG_IMAGE_WIDTH:   prdata = 32'(r_cfg_width);
            bbv_pkg::REG_CHANNEL_COUNT: prdata = 32'(r_cfg_chn);
            bbv_pkg::REG_WINDOW_SIZE:   prdata = 32'(r_cfg_win);
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // effective register values, zero acts as one, large values clamp
    always_comb begin
        w32  = 32'(r_cfg_width);
        ch32 = 32'(r_cfg_chn);
        k32  = 32'(r_cfg_win);
        if (w32 == 32'd0)                 w32  = 32'd1;
        else if (w32 > 32'(MAX_WIDTH))    w32  = 32'(MAX_WIDTH);
        if (ch32 == 32'd0)                ch32 = 32'd1;
        else if (ch32 > 32'(MAX_CHANNELS)) ch32 = 32'(MAX_CHANNELS);
        if (k32 == 32'd0)                 k32  = 32'd1;
        else if (k32 > 32'(MAX_WINDOW))   k32  = 32'(MAX_WINDOW);
        eff_w   = WEW'(w32);
        eff_chn = CHEW'(ch32);
        eff_k   = KW'(k32);
    end

    // positions seen by the incoming sample
    always_comb begin
        a_col  = i_frame_start ? '0 : r_col;
        a_h    = i_frame_start ? '0 : r_chp;
        a_row  = i_frame_start ? '0 : r_row;
        a_slot = i_frame_start ? '0 : r_slot;
        if (CHEW'(a_h) >= eff_chn)  a_h   = '0;
        if (WEW'(a_col) >= eff_w)   a_col = '0;
        lines_ready = (32'(a_row) + 32'd1) >= 32'(eff_k);
    end

    // positions after the current sample
    always_comb begin
        u_col  = r_c;
        u_h    = r_h;
        u_row  = r_row;
        u_slot = r_slot;
        if (CHEW'(r_h) + CHEW'(1) >= r_chn) begin
            u_h = '0;
            if (WEW'(r_c) + WEW'(1) >= r_w) begin
                u_col = '0;
                if (r_row != {RW{1'b1}}) u_row = r_row + RW'(1);
                u_slot = (32'(r_slot) + 32'd1 >= 32'(ROW_SLOTS)) ? '0 : r_slot + SLW'(1);
            end else begin
                u_col = r_c + COLW'(1);
            end
        end else begin
            u_h = r_h + HW'(1);
        end
    end

    assign out_cond    = r_win_full && ((32'(r_c) + 32'd1) >= 32'(r_k));
    assign row_end_now = (WEW'(r_c) == r_w - WEW'(1)) && (CHEW'(r_h) == r_chn - CHEW'(1));
    assign pos_step    = ((r_state == S_WR) && !out_cond) || emit_go;

    // memory addresses and strobes
    always_comb begin
        rs32 = 32'(r_slot) + 32'(ROW_SLOTS) - 32'(r_j);
        if (rs32 >= 32'(ROW_SLOTS)) rs32 = rs32 - 32'(ROW_SLOTS);
        ls_rd_en = (r_state == S_LRD);
        ls_wr_en = (r_state == S_WR);
        if (r_state == S_WR) tmp32 = 32'(r_slot);
        else                 tmp32 = rs32;
        ls_addr  = LSAW'(tmp32 * 32'(LS_ROW) + 32'(r_c) * 32'(MAX_CHANNELS) + 32'(r_h));
        cs_rd_en = (r_state == S_CRD);
        cs_wr_en = (r_state == S_WR) || (r_state == S_CLR);
        cs_wdata = (r_state == S_CLR) ? '0 : r_cs;
        if (r_state == S_CLR)
            cs_addr = r_clr_addr;
        else if (r_state == S_CRD)
            cs_addr = CSAW'((32'(r_c) - 32'(r_j)) * 32'(MAX_CHANNELS) + 32'(r_h));
        else
            cs_addr = CSAW'(32'(r_c) * 32'(MAX_CHANNELS) + 32'(r_h));
    end

    // line store memory
    always_ff @(posedge i_clk) begin
        if (ls_wr_en) r_ls_mem[ls_addr] <= r_sample;
        if (ls_rd_en) r_ls_rd <= r_ls_mem[ls_addr];
    end

    // column sum memory
    always_ff @(posedge i_clk) begin
        if (cs_wr_en) r_cs_mem[cs_addr] <= cs_wdata;
        if (cs_rd_en) r_cs_rd <= r_cs_mem[cs_addr];
    end

    // divider compare operands
    assign rem_x = DCW'(r_rem);
    assign dvs_x = DCW'(r_dvs);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_chp       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result held until its output transfer, refilled by the emit step
            r_out_valid <= emit_go || (r_out_valid && !i_ready);
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + CSAW'(1);
                    if (32'(r_clr_addr) == 32'(CS_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_row  <= a_row;
                        r_slot <= a_slot;
                        r_state <= (lines_ready && eff_k > KW'(1)) ? S_LRD : S_WR;
                    end
                end
                S_LRD:  r_state <= S_LACC;
                S_LACC: r_state <= (r_j + KW'(1) < r_k) ? S_LRD : S_WR;
                S_WR: begin
                    if (out_cond) begin
                        r_state <= (r_k > KW'(1)) ? S_CRD : S_DSET;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CRD:  r_state <= S_CACC;
                S_CACC: r_state <= (r_j + KW'(1) < r_k) ? S_CRD : S_DSET;
                S_DSET: r_state <= S_DIV;
                S_DIV:  if (r_step == 3'd7) r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_go) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // advance raster position
            if (pos_step) begin
                r_col  <= u_col;
                r_chp  <= u_h;
                r_row  <= u_row;
                r_slot <= u_slot;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_w        <= eff_w;
                    r_chn      <= eff_chn;
                    r_k        <= eff_k;
                    r_kk       <= KKW'(32'(eff_k) * 32'(eff_k));
                    r_c        <= a_col;
                    r_h        <= a_h;
                    r_sample   <= i_sample;
                    r_cs       <= CSW'(i_sample);
                    r_j        <= KW'(1);
                    r_win_full <= lines_ready;
                end
            end
            S_LACC: begin
                r_cs <= r_cs + CSW'(r_ls_rd);
                r_j  <= r_j + KW'(1);
            end
            S_WR: begin
                r_sum     <= SUMW'(r_cs);
                r_j       <= KW'(1);
            end
            S_CACC: begin
                r_sum <= r_sum + SUMW'(r_cs_rd);
                r_j   <= r_j + KW'(1);
            end
            S_DSET: begin
                r_rem  <= r_sum;
                r_dvs  <= DVW'({r_kk, {(QW-1){1'b0}}});
                r_q    <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_x >= dvs_x) begin
                    r_rem <= SUMW'(rem_x - dvs_x);
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step + 3'd1;
            end
            S_EMIT: begin
                if (emit_go) begin
                    r_out_data <= r_q;
                    r_out_end  <= row_end_now;
                end
            end
            default: ;
        endcase
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_blurred_sample = r_out_data;
    assign o_row_end        = r_out_end;

endmodule

/* design/bbv_checker.sv */
// ----------------------------------------------------------------------------
// bbv_checker
// Port-level checks for the box blur block, bound to the top level.
// ----------------------------------------------------------------------------
module bbv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         pready,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [bbv_pkg::SAMPLE_W-1:0] o_blurred_sample,
    input logic                         o_row_end
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_blurred_sample) && $stable(o_row_end)))
        else $error("output payload changed while stalled");

    // reset leaves no result pending and the block busy clearing
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("output or input open right after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second input transfer taken back to back");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind box_blur_valid_window bbv_checker u_bbv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .pready           (pready),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_blurred_sample (o_blurred_sample),
    .o_row_end        (o_row_end)
);

/* dv/tb_box_blur_valid_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_valid_window
// Self-checking bench for the valid-area box blur. A short partial frame and
// a directed table come first, then more directed cases and random frames over many register settings. Every
// accepted sample goes through a local blur predictor. Every output transfer
// is compared in order with the expected window means.
// ----------------------------------------------------------------------------
module tb_box_blur_valid_window;

    localparam int MAX_W    = 1024;
    localparam int MAX_CH   = 4;
    localparam int MAX_K    = 15;
    localparam int N_SLOTS  = MAX_K - 1;
    localparam int N_ITEMS  = 1500;
    localparam int SETTLE   = 4 * MAX_K + 40;

    typedef struct packed {
        logic [bbv_pkg::SAMPLE_W-1:0] avg;
        logic                         row_end;
    } t_blur_out;

    typedef struct {
        logic [bbv_pkg::SAMPLE_W-1:0] sample;
        logic                         frame_start;
        bit                           typed;
        t_blur_out                    typed_out;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bbv_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_ready;
    logic [bbv_pkg::SAMPLE_W-1:0] i_sample;
    logic                         i_frame_start;
    logic                         o_valid;
    logic                         i_ready;
    logic [bbv_pkg::SAMPLE_W-1:0] o_blurred_sample;
    logic                         o_row_end;

    box_blur_valid_window u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_frame_start    (i_frame_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_blurred_sample (o_blurred_sample),
        .o_row_end        (o_row_end)
    );

    // predictor state
    logic [bbv_pkg::IMG_WIDTH_W-1:0] cfg_width;
    logic [bbv_pkg::CHN_COUNT_W-1:0] cfg_chans;
    logic [bbv_pkg::WIN_SIZE_W-1:0]  cfg_win;
    logic [7:0]             row_lines [0:N_SLOTS*MAX_W*MAX_CH-1];
    int unsigned            col_sum [0:MAX_W*MAX_CH-1];
    int unsigned            col_pos, chan_pos, row_pos, slot_pos;

    t_blur_out   expected_means[$];
    t_row        pending_row;
    bit          use_typed;
    int unsigned n_errors, n_sent, n_results, n_settings;
    int unsigned tx_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // limit
    initial begin
        #50ms;
        $display("box_blur_valid_window: mismatch");
        $finish;
    end

    function automatic int unsigned clamp_val(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // one sample through the blur, returns whether a mean comes out
    function automatic bit blur_predict(input logic [7:0] s, input logic fs,
                                        output t_blur_out res);
        int unsigned w, chn, k, c, h, vsum, wsum, sl;
        w   = clamp_val(cfg_width, MAX_W);
        chn = clamp_val(cfg_chans, MAX_CH);
        k   = clamp_val(cfg_win, MAX_K);
        res = '0;
        if (fs) begin
            col_pos = 0; chan_pos = 0; row_pos = 0; slot_pos = 0;
        end
        if (chan_pos >= chn) chan_pos = 0;
        if (col_pos >= w) col_pos = 0;
        if (slot_pos >= N_SLOTS) slot_pos = 0;
        c = col_pos;
        h = chan_pos;
        // vertical sum over the newest k rows
        vsum = s;
        if (row_pos + 1 >= k) begin
            for (int j = 1; j < k; j++) begin
                sl = (slot_pos + N_SLOTS - j) % N_SLOTS;
                vsum += row_lines[(sl * MAX_W + c) * MAX_CH + h];
            end
        end
        row_lines[(slot_pos * MAX_W + c) * MAX_CH + h] = s;
        col_sum[c * MAX_CH + h] = vsum;
        blur_predict = 1'b0;
        if (row_pos + 1 >= k && c + 1 >= k) begin
            wsum = 0;
            for (int j = 0; j < k; j++) wsum += col_sum[(c - j) * MAX_CH + h];
            res.avg     = 8'(wsum / (k * k));
            res.row_end = (c == w - 1 && h == chn - 1);
            blur_predict = 1'b1;
        end
        // advance raster position
        chan_pos = h + 1;
        if (chan_pos >= chn) begin
            chan_pos = 0;
            col_pos  = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                if (row_pos < 16'hFFFF) row_pos++;
                slot_pos = (slot_pos + 1) % N_SLOTS;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // input and output transfers, checked at each edge
    always @(posedge i_clk) begin
        t_blur_out want;
        t_blur_out pred;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_means.size() == 0) begin
                report_mismatch("unexpected result, sample", o_blurred_sample, 0);
            end else begin
                want = expected_means.pop_front();
                if (o_blurred_sample !== want.avg)
                    report_mismatch("blurred_sample", o_blurred_sample, want.avg);
                if (o_row_end !== want.row_end)
                    report_mismatch("row_end", o_row_end, want.row_end);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            tx_count++;
            if (blur_predict(i_sample, i_frame_start, pred))
                expected_means.push_back(use_typed ? pending_row.typed_out : pred);
        end
    end

    // receiver stalls in patterns chosen at random
    initial begin
        int unsigned mode;
        i_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(50, 400)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 1);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ~i_ready;
                endcase
            end
        end
    end

    // apb write, also updates the predictor copy
    task automatic reg_write(input bbv_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bbv_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bbv_pkg::REG_IMAGE_WIDTH:   cfg_width = val[bbv_pkg::IMG_WIDTH_W-1:0];
            bbv_pkg::REG_CHANNEL_COUNT: cfg_chans = val[bbv_pkg::CHN_COUNT_W-1:0];
            bbv_pkg::REG_WINDOW_SIZE:   cfg_win   = val[bbv_pkg::WIN_SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned w, input int unsigned ch,
                              input int unsigned k);
        reg_write(bbv_pkg::REG_IMAGE_WIDTH, w);
        reg_write(bbv_pkg::REG_CHANNEL_COUNT, ch);
        reg_write(bbv_pkg::REG_WINDOW_SIZE, k);
        n_settings++;
    endtask

    // wait until every expected mean has arrived and the block has settled
    task automatic drain();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sender burst bookkeeping
    int unsigned burst_left;
    bit          gapless;

    task automatic send_sample(input logic [7:0] s, input logic fs);
        int unsigned before_tx;
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_frame_start <= fs;
        before_tx = tx_count;
        @(posedge i_clk);
        while (tx_count == before_tx) @(posedge i_clk);
        n_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0) gapless = ~gapless;
            if (!gapless) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // random frame, optionally continuing the current one with no frame start
    task automatic send_frame(input int unsigned rows, input bit keep_on);
        int unsigned w, chn, total;
        logic        fs;
        w     = clamp_val(cfg_width, MAX_W);
        chn   = clamp_val(cfg_chans, MAX_CH);
        total = rows * w * chn;
        for (int unsigned n = 0; n < total; n++) begin
            fs = (n == 0 && !keep_on) || ($urandom_range(0, 199) == 0);
            send_sample(8'($urandom), fs);
        end
    endtask

    t_row dir_table[$];

    function automatic t_row mk_row(input logic [7:0] s, input logic fs, input bit typed,
                                    input logic [7:0] avg, input logic rend);
        t_row r;
        r.sample = s; r.frame_start = fs; r.typed = typed;
        r.typed_out.avg = avg; r.typed_out.row_end = rend;
        return r;
    endfunction

    initial begin
        int unsigned w, ch, k, rows;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_sample = '0; i_frame_start = 1'b0;
        i_rst_n = 1'b0;
        cfg_width = bbv_pkg::IMG_WIDTH_RST;
        cfg_chans = bbv_pkg::CHN_COUNT_RST;
        cfg_win   = bbv_pkg::WIN_SIZE_RST;
        col_pos = 0; chan_pos = 0; row_pos = 0; slot_pos = 0;
        foreach (col_sum[i]) col_sum[i] = 0;
        n_errors = 0; n_sent = 0; n_results = 0; n_settings = 0; tx_count = 0;
        burst_left = 1; gapless = 1'b0; use_typed = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 640 wide, 3 channels, 3x3, one short partial frame
        for (int n = 0; n < 12; n++) send_sample(8'($urandom), n == 0);
        drain();

        // directed: 1x1 window passes samples straight through
        set_config(2, 1, 1);
        dir_table.push_back(mk_row(8'h00, 1'b1, 1, 8'h00, 1'b0));
        dir_table.push_back(mk_row(8'hFF, 1'b0, 1, 8'hFF, 1'b1));
        dir_table.push_back(mk_row(8'hAA, 1'b0, 1, 8'hAA, 1'b0));
        dir_table.push_back(mk_row(8'h55, 1'b0, 1, 8'h55, 1'b1));
        // frame start in the middle of a row restarts at column zero
        dir_table.push_back(mk_row(8'h01, 1'b0, 1, 8'h01, 1'b0));
        dir_table.push_back(mk_row(8'h80, 1'b1, 1, 8'h80, 1'b0));
        dir_table.push_back(mk_row(8'h7F, 1'b0, 1, 8'h7F, 1'b1));
        foreach (dir_table[i]) begin
            pending_row = dir_table[i];
            use_typed   = dir_table[i].typed;
            send_sample(dir_table[i].sample, dir_table[i].frame_start);
        end
        drain();
        use_typed = 1'b0;
        dir_table.delete();

        // directed: 2x2 window over all-max samples, then all-zero
        set_config(2, 2, 2);
        for (int n = 0; n < 8; n++) send_sample(8'hFF, n == 0);
        for (int n = 0; n < 8; n++) send_sample(8'h00, n == 0);
        drain();

        // window wider than the image: nothing comes out
        set_config(2, 1, 3);
        for (int n = 0; n < 8; n++) send_sample(8'($urandom), n == 0);
        drain();

        // register values out of range: zeros and a channel count above the maximum
        set_config(0, 0, 0);
        for (int n = 0; n < 6; n++) send_sample(8'($urandom), n == 0);
        drain();
        set_config(3, 7, 15);
        send_frame(2, 1'b0);
        drain();

        // widest row: 2047 clamps to the maximum width, one channel, 1x1
        set_config(2047, 1, 1);
        send_frame(1, 1'b0);
        for (int n = 0; n < 4; n++) send_sample(8'($urandom), 1'b0);
        drain();

        // largest window on a 16-wide image
        set_config(16, 1, 15);
        send_frame(16, 1'b0);
        drain();

        // random frames
        while (n_sent < N_ITEMS) begin
            w  = $urandom_range(1, 12);
            ch = $urandom_range(1, 4);
            k  = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0: k = 0;
                1: ch = 0;
                2: w = 0;
                3: begin w = 1; k = 1; end
                default: ;
            endcase
            set_config(w, ch, k);
            rows = clamp_val(k, MAX_K) + $urandom_range(0, 4);
            send_frame(rows, 1'b0);
            // occasionally narrow the image and pick a new channel count in the middle of a frame
            if ($urandom_range(0, 3) == 0 && clamp_val(w, MAX_W) > 1) begin
                drain();
                reg_write(bbv_pkg::REG_IMAGE_WIDTH,
                          $urandom_range(1, clamp_val(w, MAX_W) - 1));
                reg_write(bbv_pkg::REG_CHANNEL_COUNT,
                          $urandom_range(1, clamp_val(ch, MAX_CH)));
                n_settings++;
                send_frame(2, 1'b1);
            end
            drain();
        end

        $display("covered %0d samples, %0d means, %0d register settings",
                 n_sent, n_results, n_settings);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0 && expected_means.size() == 0) begin
            $display("box_blur_valid_window: match");
        end else begin
            $display("box_blur_valid_window: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/bbv_pkg.sv
design/box_blur_valid_window.sv
design/bbv_checker.sv
dv/tb_box_blur_valid_window.sv
